[design/sat_pkg.sv]
// sat_pkg: shared types and constants of the section address translator.
// No dependencies; imported by the top level and the testbench.
package sat_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned OFFSET_W  = 33;
    localparam int unsigned INDEX_W   = 7;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SHIFT   = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] raw_size;
        logic [WORD_W-1:0] raw_pointer;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

endpackage

[design/sat_ram.sv]
// sat_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module sat_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 96,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/section_address_translator_top.sv]
// section_address_translator_top: section table in sat_ram and a sequential lookup.
// Depends on sat_pkg and sat_ram.
//
//  channel   | signals                                         | direction
//  ----------+-------------------------------------------------+----------
//  item      | i_start, o_busy, i_operation .. i_address       | in
//  result    | o_valid, o_hit, o_section_index, o_offset_valid,| out
//            | o_file_offset                                   |
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data| in
//
// A write item leaves o_busy low. A translate item keeps o_busy high while the table
// is searched from entry 0 up to the matching entry (or the last live entry on a miss);
// the result strobes in the cycle after. With section_count zero the miss strobes
// the next cycle. The RAM read port gives one entry a cycle. Reset is synchronous,
// active low; no clearing pass. Results cannot be stalled.
module section_address_translator_top #(
    parameter int unsigned MAX_SECTIONS = 96
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_operation,
    input  logic [sat_pkg::INDEX_W-1:0]         i_entry_index,
    input  logic [sat_pkg::WORD_W-1:0]          i_section_start,
    input  logic [sat_pkg::WORD_W-1:0]          i_section_size,
    input  logic [sat_pkg::WORD_W-1:0]          i_raw_size,
    input  logic [sat_pkg::WORD_W-1:0]          i_raw_pointer,
    input  logic [sat_pkg::WORD_W-1:0]          i_address,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic [sat_pkg::INDEX_W-1:0]         o_section_index,
    output logic                                o_offset_valid,
    output logic [sat_pkg::OFFSET_W-1:0]        o_file_offset,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sat_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sat_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import sat_pkg::*;

    localparam int unsigned AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SECTIONS);

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_section_count;
    logic [SHIFT_W-1:0]   r_align_shift;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [COUNT_W-1:0]   r_issue_cnt, n_issue_cnt;
    logic [WORD_W-1:0]    r_addr;

    logic                 r_v1, r_v2;
    logic [INDEX_W-1:0]   r_idx1, r_idx2;
    logic                 r_last1, r_last2;
    logic [WORD_W-1:0]    r_off;
    logic                 r_ge;
    logic [OFFSET_W-1:0]  r_span;
    logic [WORD_W-1:0]    r_raw_size, r_raw_ptr;

    logic                 r_out_valid, r_out_hit, r_out_ov;
    logic [INDEX_W-1:0]   r_out_idx;
    logic [OFFSET_W-1:0]  r_out_fo;

    logic                 accept, ram_we, issue, finish, in_span, off_ok;
    logic [COUNT_W-1:0]   sat_count;
    t_entry               wr_entry, rd_entry;
    logic [OFFSET_W-1:0]  diff, mask, span, fo;

    assign accept    = i_start && !o_busy;
    assign ram_we    = accept && (i_operation == OP_WRITE) && (i_entry_index < MAX_COUNT);
    assign sat_count = (r_section_count > MAX_COUNT) ? MAX_COUNT : r_section_count;

    assign wr_entry.start       = i_section_start;
    assign wr_entry.size        = i_section_size;
    assign wr_entry.raw_size    = i_raw_size;
    assign wr_entry.raw_pointer = i_raw_pointer;

    sat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SECTIONS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_entry_index[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_issue_cnt[AW-1:0]),
        .o_rdata (rd_entry)
    );

    // stage 1: offset and aligned span from the entry just read
    assign diff = {1'b0, r_addr} - {1'b0, rd_entry.start};
    assign mask = (OFFSET_W'(1) << r_align_shift) - OFFSET_W'(1);
    assign span = ({1'b0, rd_entry.size} + mask) & ~mask;

    // stage 2: decide
    assign in_span = r_ge && ({1'b0, r_off} < r_span);
    assign off_ok  = r_off < r_raw_size;
    assign fo      = {1'b0, r_raw_ptr} + {1'b0, r_off};
    assign finish  = (r_state == S_SEARCH) && r_v2 && (in_span || r_last2);
    assign issue   = (r_state == S_SEARCH) && !finish && (r_issue_cnt < r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue_cnt = r_issue_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_operation == OP_TRANSLATE) && (sat_count != '0)) begin
                    n_state     = S_SEARCH;
                    n_count     = sat_count;
                    n_issue_cnt = '0;
                end
            end
            S_SEARCH: begin
                if (finish) begin
                    n_state = S_IDLE;
                end else if (issue) begin
                    n_issue_cnt = r_issue_cnt + COUNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_section_count <= COUNT_RESET;
            r_align_shift   <= SHIFT_RESET;
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SECTION_COUNT: r_section_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_ALIGN_SHIFT:   r_align_shift   <= i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            r_v1        <= issue;
            r_v2        <= r_v1 && !finish;
            r_out_valid <= finish ||
                           (accept && (i_operation == OP_TRANSLATE) && (sat_count == '0));
        end
    end

    always_ff @(posedge i_clk) begin
        r_count     <= n_count;
        r_issue_cnt <= n_issue_cnt;
        if (accept) begin
            r_addr <= i_address;
        end
        r_idx1     <= r_issue_cnt;
        r_last1    <= (r_issue_cnt == (r_count - COUNT_W'(1)));
        r_idx2     <= r_idx1;
        r_last2    <= r_last1;
        r_off      <= diff[WORD_W-1:0];
        r_ge       <= !diff[OFFSET_W-1];
        r_span     <= span;
        r_raw_size <= rd_entry.raw_size;
        r_raw_ptr  <= rd_entry.raw_pointer;
        if (finish && in_span) begin
            r_out_hit <= 1'b1;
            r_out_idx <= r_idx2;
            r_out_ov  <= off_ok;
            r_out_fo  <= off_ok ? fo : '0;
        end else begin
            r_out_hit <= 1'b0;
            r_out_idx <= '0;
            r_out_ov  <= 1'b0;
            r_out_fo  <= '0;
        end
    end

    assign o_busy          = (r_state == S_SEARCH);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_section_index = r_out_idx;
    assign o_offset_valid  = r_out_ov;
    assign o_file_offset   = r_out_fo;

`ifndef SYNTHESIS
    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("table written during a search");

    a_issue_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_issue_cnt <= r_count))
        else $error("read index ran past section count");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_state == S_IDLE) && o_valid)
        else $error("search end did not give a result");

    a_ov_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_offset_valid) |-> o_hit)
        else $error("offset valid without hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> ((o_section_index == '0) && (o_file_offset == '0)))
        else $error("miss carries nonzero fields");
`endif

endmodule

[test/tb_section_address_translator_top.sv]
`timescale 1ns / 1ps
// tb_section_address_translator_top: self-checking bench for the section address translator.
// Drives write/translate items and register writes, predicts every translation in the bench.
// Depends on sat_pkg and section_address_translator_top.
module tb_section_address_translator_top;
    import sat_pkg::*;

    localparam int unsigned SECTIONS       = 96;
    localparam int unsigned SETTLE_CYCLES  = SECTIONS + 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic               operation;
        logic [INDEX_W-1:0] entry_index;
        t_entry             entry;
        logic [WORD_W-1:0]  address;
    } t_section_item;

    typedef struct {
        logic                hit;
        logic [INDEX_W-1:0]  section_index;
        logic                offset_valid;
        logic [OFFSET_W-1:0] file_offset;
    } t_translation;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_start         = 1'b0;
    logic                 i_operation     = OP_WRITE;
    logic [INDEX_W-1:0]   i_entry_index   = '0;
    logic [WORD_W-1:0]    i_section_start = '0;
    logic [WORD_W-1:0]    i_section_size  = '0;
    logic [WORD_W-1:0]    i_raw_size      = '0;
    logic [WORD_W-1:0]    i_raw_pointer   = '0;
    logic [WORD_W-1:0]    i_address       = '0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_SECTION_COUNT;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;

    logic                o_busy;
    logic                o_valid;
    logic                o_hit;
    logic [INDEX_W-1:0]  o_section_index;
    logic                o_offset_valid;
    logic [OFFSET_W-1:0] o_file_offset;
    logic                o_cfg_ready;

    t_entry             section_entries [SECTIONS];
    t_entry             planned_entries [SECTIONS];
    logic [COUNT_W-1:0] searched_count = COUNT_RESET;
    logic [SHIFT_W-1:0] align_log2     = SHIFT_RESET;

    t_section_item pending_items [$];
    t_translation  expected_translations [$];
    t_section_item driven_item;
    logic          item_loaded  = 1'b0;
    logic          idle_bursts  = 1'b1;
    int unsigned   gap_left     = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   failures     = 0;

    section_address_translator_top #(
        .MAX_SECTIONS(SECTIONS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_section_start(i_section_start),
        .i_section_size (i_section_size),
        .i_raw_size     (i_raw_size),
        .i_raw_pointer  (i_raw_pointer),
        .i_address      (i_address),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_section_index(o_section_index),
        .o_offset_valid (o_offset_valid),
        .o_file_offset  (o_file_offset),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned live_entries();
        return (searched_count > SECTIONS) ? SECTIONS : searched_count;
    endfunction

    // size rounded up to 2^shift, 33 bits so a full 4 GiB span fits
    function automatic logic [OFFSET_W-1:0] aligned_span(logic [WORD_W-1:0] size,
                                                         logic [SHIFT_W-1:0] shift);
        logic [OFFSET_W-1:0] mask;
        mask = {OFFSET_W{1'b1}} >> (OFFSET_W - shift);
        return ({1'b0, size} + mask) & ~mask;
    endfunction

    function automatic t_translation translate_address(logic [WORD_W-1:0] address);
        t_translation      found;
        logic [WORD_W-1:0] rel;
        found.hit           = 1'b0;
        found.section_index = '0;
        found.offset_valid  = 1'b0;
        found.file_offset   = '0;
        for (int unsigned i = 0; i < live_entries(); i++) begin
            rel = address - section_entries[i].start;
            if (address >= section_entries[i].start &&
                {1'b0, rel} < aligned_span(section_entries[i].size, align_log2)) begin
                found.hit           = 1'b1;
                found.section_index = i[INDEX_W-1:0];
                if (rel < section_entries[i].raw_size) begin
                    found.offset_valid = 1'b1;
                    found.file_offset  = {1'b0, section_entries[i].raw_pointer} + {1'b0, rel};
                end
                return found;
            end
        end
        return found;
    endfunction

    function automatic void accept_item(t_section_item it);
        if (it.operation == OP_WRITE) begin
            if (it.entry_index < SECTIONS) begin
                section_entries[it.entry_index] = it.entry;
            end
        end else begin
            expected_translations.push_back(translate_address(it.address));
        end
    endfunction

    function automatic t_entry random_entry();
        t_entry e;
        case ($urandom_range(0, 3))
            0: e.start = $urandom;
            1: e.start = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
            default: e.start = $urandom_range(0, 32'h000F_FFFF) << 12;
        endcase
        case ($urandom_range(0, 19))
            0: e.size = '0;
            1: e.size = 32'hFFFF_FFFF;
            2: e.size = $urandom;
            default: e.size = $urandom_range(1, 32'h0000_4000);
        endcase
        case ($urandom_range(0, 5))
            0: e.raw_size = '0;
            1: e.raw_size = 32'hFFFF_FFFF;
            2: e.raw_size = $urandom;
            3: e.raw_size = e.size >> 1;
            default: e.raw_size = e.size;
        endcase
        if ($urandom_range(0, 1) == 0) begin
            e.raw_pointer = $urandom;
        end else begin
            e.raw_pointer = 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
        end
        return e;
    endfunction

    function automatic void plan_write(logic [INDEX_W-1:0] index, t_entry e);
        t_section_item it;
        it.operation   = OP_WRITE;
        it.entry_index = index;
        it.entry       = e;
        it.address     = $urandom;
        if (index < SECTIONS) begin
            planned_entries[index] = e;
        end
        pending_items.push_back(it);
    endfunction

    function automatic void plan_translate(logic [WORD_W-1:0] address);
        t_section_item it;
        it.operation   = OP_TRANSLATE;
        it.entry_index = INDEX_W'($urandom_range(0, 127));
        it.entry       = random_entry();
        it.address     = address;
        pending_items.push_back(it);
    endfunction

    // mostly addresses at and around a live section's span and raw edges
    function automatic logic [WORD_W-1:0] pick_address();
        int unsigned         j;
        logic [OFFSET_W-1:0] span;
        logic [OFFSET_W-1:0] off;
        logic [63:0]         wide;
        if (live_entries() == 0 || $urandom_range(0, 9) < 2) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return '1;
                default: return $urandom;
            endcase
        end
        j    = $urandom_range(0, live_entries() - 1);
        span = aligned_span(planned_entries[j].size, align_log2);
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: off = '0;
            1: off = span - 1;
            2: off = span;
            3: off = {1'b0, planned_entries[j].raw_size};
            4: off = {1'b0, planned_entries[j].raw_size} - 1;
            default: begin
                if (span == 0) begin
                    off = '0;
                end else begin
                    off = OFFSET_W'(wide % span);
                end
            end
        endcase
        return planned_entries[j].start + off[WORD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) begin
                accept_item(driven_item);
                item_loaded = 1'b0;
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_start <= 1'b0;
            end else if (pending_items.size() > 0 && idle_bursts &&
                         $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(0, 7);
                i_start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                driven_item = pending_items.pop_front();
                item_loaded = 1'b1;
                i_start         <= 1'b1;
                i_operation     <= driven_item.operation;
                i_entry_index   <= driven_item.entry_index;
                i_section_start <= driven_item.entry.start;
                i_section_size  <= driven_item.entry.size;
                i_raw_size      <= driven_item.entry.raw_size;
                i_raw_pointer   <= driven_item.entry.raw_pointer;
                i_address       <= driven_item.address;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_translation want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_translations.size() == 0) begin
                $error("result with no translate item outstanding");
                failures++;
            end else begin
                want = expected_translations.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    failures++;
                end
                if (o_section_index !== want.section_index) begin
                    $error("section_index: expected %0d, got %0d",
                           want.section_index, o_section_index);
                    failures++;
                end
                if (o_offset_valid !== want.offset_valid) begin
                    $error("offset_valid: expected %0d, got %0d",
                           want.offset_valid, o_offset_valid);
                    failures++;
                end
                if (o_file_offset !== want.file_offset) begin
                    $error("file_offset: expected 0x%09h, got 0x%09h",
                           want.file_offset, o_file_offset);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_valid === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (index == CFG_SECTION_COUNT) begin
            searched_count = data[COUNT_W-1:0];
        end else if (index == CFG_ALIGN_SHIFT) begin
            align_log2 = data[SHIFT_W-1:0];
        end
    endtask

    // sender holds off until every translation is back and the block has gone quiet
    task automatic drain();
        while (pending_items.size() != 0 || item_loaded || expected_translations.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int unsigned items, input int unsigned write_pct);
        for (int unsigned n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < write_pct) begin
                if ($urandom_range(0, 9) == 0) begin
                    plan_write(INDEX_W'($urandom_range(SECTIONS, 127)), random_entry());
                end else begin
                    plan_write(INDEX_W'($urandom_range(0, SECTIONS - 1)), random_entry());
                end
            end else begin
                plan_translate(pick_address());
            end
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: every lookup misses at once
        plan_translate(32'h0000_0000);
        plan_translate(32'hFFFF_FFFF);
        plan_write(7'd127, random_entry());
        plan_write(7'd96, random_entry());
        plan_write(7'd0, '{32'h0000_1000, 32'h0000_1800, 32'h0000_1000, 32'h0000_0400});
        plan_write(7'd1, '{32'h0000_1000, 32'h0000_0010, 32'h0000_0010, 32'h0000_0000});
        plan_write(7'd2, '{32'h0000_8000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
        plan_write(7'd3, '{32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        drain();

        // span edges, raw edges, overlap, empty section, carry into bit 32
        write_register(CFG_SECTION_COUNT, 7'd4);
        plan_translate(32'h0000_1000);
        plan_translate(32'h0000_1FFF);
        plan_translate(32'h0000_2000);
        plan_translate(32'h0000_2FFF);
        plan_translate(32'h0000_3000);
        plan_translate(32'h0000_0FFF);
        plan_translate(32'h0000_8000);
        plan_translate(32'hFFFF_F000);
        plan_translate(32'hFFFF_FFFF);
        drain();

        write_register(CFG_ALIGN_SHIFT, 7'd0);
        plan_translate(32'h0000_27FF);
        plan_translate(32'h0000_2800);
        plan_translate(32'hFFFF_FFFF);
        drain();

        write_register(CFG_ALIGN_SHIFT, 7'h7F);
        plan_translate(32'h8000_0FFF);
        plan_translate(32'h8000_1000);
        drain();

        write_register(CFG_SPARE_A, 7'h7F);
        write_register(CFG_SPARE_B, 7'h00);
        write_register(CFG_ALIGN_SHIFT, 7'h0C);
        for (int unsigned i = 4; i < SECTIONS; i++) begin
            plan_write(i[INDEX_W-1:0], random_entry());
            if (i % 4 == 0) begin
                plan_translate(pick_address());
            end
        end
        drain();

        write_register(CFG_SECTION_COUNT, 7'd96);
        random_phase(150, 20);

        write_register(CFG_SECTION_COUNT, 7'd127);
        write_register(CFG_ALIGN_SHIFT, 7'd0);
        random_phase(150, 20);

        idle_bursts = 1'b0;
        write_register(CFG_SECTION_COUNT, 7'd1);
        write_register(CFG_ALIGN_SHIFT, 7'h7F);
        random_phase(80, 20);
        idle_bursts = 1'b1;

        write_register(CFG_SECTION_COUNT, 7'd0);
        write_register(CFG_ALIGN_SHIFT, 7'h45);
        random_phase(40, 30);

        write_register(CFG_SECTION_COUNT, 7'd40);
        write_register(CFG_ALIGN_SHIFT, 7'h10);
        random_phase(150, 20);

        write_register(CFG_SECTION_COUNT, 7'd100);
        write_register(CFG_ALIGN_SHIFT, 7'h09);
        random_phase(150, 20);

        write_register(CFG_SECTION_COUNT, CFG_DAT_W'($urandom_range(2, SECTIONS - 1)));
        write_register(CFG_ALIGN_SHIFT, CFG_DAT_W'($urandom_range(0, 31)));
        random_phase(150, 20);

        idle_bursts = 1'b0;
        write_register(CFG_SECTION_COUNT, 7'd96);
        write_register(CFG_ALIGN_SHIFT, 7'h2C);
        random_phase(150, 20);

        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
